// ----- src/tcl_pkg.sv -----
// ----------------------------------------------------------------------------
// tcl_pkg
// shared types and constants of the text cursor layout block
// ----------------------------------------------------------------------------
package tcl_pkg;

	// glyph cell size in pixels, fixed by the font
	localparam int CELL       = 8;
	localparam int CELL_SHIFT = 3;

	// request codes
	localparam logic REQ_BEGIN = 1'b0;
	localparam logic REQ_CHAR  = 1'b1;

	// result kinds
	localparam logic KIND_GLYPH  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// control character codes
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// result queue
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic       kind;
		logic [9:0] pixel_x;
		logic [9:0] pixel_y;
		logic [7:0] symbol;
		logic [7:0] glyph_color;
		logic [7:0] lines_ended;
		logic       last;
	} tcl_result_t;

	// up to two results produced by one item, in order
	typedef struct packed {
		logic [1:0]  count;
		tcl_result_t first;
		tcl_result_t second;
	} tcl_push_t;

endpackage

// ----- src/tcl_if.sv -----
// ----------------------------------------------------------------------------
// tcl channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface tcl_item_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [9:0] start_x;
	logic [9:0] start_y;
	logic [7:0] max_cols;
	logic [7:0] max_rows;
	logic [7:0] ink_color;
	logic [7:0] char_code;

	modport source (
		output valid, req_type, start_x, start_y, max_cols, max_rows, ink_color,
			char_code,
		input  ready
	);
	modport sink (
		input  valid, req_type, start_x, start_y, max_cols, max_rows, ink_color,
			char_code,
		output ready
	);
endinterface

interface tcl_result_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [9:0] pixel_x;
	logic [9:0] pixel_y;
	logic [7:0] symbol;
	logic [7:0] glyph_color;
	logic [7:0] lines_ended;
	logic       last;

	modport source (
		output valid, kind, pixel_x, pixel_y, symbol, glyph_color, lines_ended, last,
		input  ready
	);
	modport sink (
		input  valid, kind, pixel_x, pixel_y, symbol, glyph_color, lines_ended, last,
		output ready
	);
endinterface

// ----- src/tcl_layout.sv -----
// ----------------------------------------------------------------------------
// tcl_layout
// input register, cursor state and per-item layout decision
// ----------------------------------------------------------------------------
module tcl_layout #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 200,
	parameter int TAB_COLS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	tcl_item_if.sink          item,
	input  logic              room,
	output tcl_pkg::tcl_push_t push
);
	import tcl_pkg::*;

	localparam logic [7:0] W_CELLS   = 8'(SCREEN_W / CELL);
	localparam logic [7:0] H_CELLS   = 8'(SCREEN_H / CELL);
	localparam int         PW        = (TAB_COLS > 1) ? $clog2(TAB_COLS) : 1;
	localparam logic [PW-1:0] PH_LAST = PW'(TAB_COLS - 1);
	localparam logic [8:0] TAB_STEP  = 9'(TAB_COLS);
	localparam logic [9:0] TAB_PIX   = 10'(TAB_COLS * CELL);
	localparam logic [9:0] CELL_PIX  = 10'(CELL);

	// input stage
	logic       valid_s1;
	logic       req_type_s1;
	logic [9:0] start_x_s1;
	logic [9:0] start_y_s1;
	logic [7:0] max_cols_s1;
	logic [7:0] max_rows_s1;
	logic [7:0] ink_color_s1;
	logic [7:0] char_code_s1;
	logic       advance;
	logic       take;

	// cursor state
	logic          active_q,       active_d;
	logic [9:0]    left_x_q,       left_x_d;
	logic [9:0]    cursor_x_q,     cursor_x_d;
	logic [9:0]    cursor_y_q,     cursor_y_d;
	logic [7:0]    column_q,       column_d;
	logic [PW-1:0] phase_q,        phase_d;
	logic [7:0]    column_limit_q, column_limit_d;
	logic [7:0]    rows_left_q,    rows_left_d;
	logic [7:0]    line_count_q,   line_count_d;
	logic [7:0]    held_color_q,   held_color_d;

	// decision terms
	logic [7:0]  sx_cells, sy_cells, cols, rows;
	logic        off_screen;
	logic [8:0]  next_col, next_tab;
	logic [7:0]  lines_inc, rows_dec;
	logic        do_line_end, move, move_tab, glyph, done;
	tcl_result_t glyph_res, finish_res;

	assign advance    = valid_s1 && room;
	assign item.ready = !valid_s1 || room;
	assign take       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_type_s1  <= item.req_type;
			start_x_s1   <= item.start_x;
			start_y_s1   <= item.start_y;
			max_cols_s1  <= item.max_cols;
			max_rows_s1  <= item.max_rows;
			ink_color_s1 <= item.ink_color;
			char_code_s1 <= item.char_code;
		end
	end

	// begin: clip the text area to the screen
	assign sx_cells   = {1'b0, start_x_s1[9:CELL_SHIFT]};
	assign sy_cells   = {1'b0, start_y_s1[9:CELL_SHIFT]};
	assign off_screen = (sx_cells >= W_CELLS) || (sy_cells >= H_CELLS);

	always_comb begin
		cols = W_CELLS - sx_cells;
		rows = H_CELLS - sy_cells;
		if (max_cols_s1 != 8'd0 && max_cols_s1 < cols) begin
			cols = max_cols_s1;
		end
		if (max_rows_s1 != 8'd0 && max_rows_s1 < rows) begin
			rows = max_rows_s1;
		end
	end

	// next column for a plain advance and for a tab stop
	assign next_col  = {1'b0, column_q} + 9'd1;
	assign next_tab  = {1'b0, column_q} - 9'(phase_q) + TAB_STEP;
	assign lines_inc = (line_count_q == 8'hFF) ? line_count_q : line_count_q + 8'd1;
	assign rows_dec  = rows_left_q - 8'd1;

	// character decode
	always_comb begin
		do_line_end = 1'b0;
		move        = 1'b0;
		move_tab    = 1'b0;
		glyph       = 1'b0;
		done        = 1'b0;
		if (char_code_s1 == CHAR_NUL) begin
			done = 1'b1;
		end else if (char_code_s1 == CHAR_LF) begin
			do_line_end = 1'b1;
		end else if (char_code_s1 == CHAR_CR) begin
			move = 1'b0;
		end else if (char_code_s1 == CHAR_TAB) begin
			if (next_tab >= {1'b0, column_limit_q}) begin
				do_line_end = 1'b1;
			end else begin
				move_tab = 1'b1;
			end
		end else begin
			glyph = (char_code_s1 != CHAR_SPACE);
			if (next_col >= {1'b0, column_limit_q}) begin
				do_line_end = 1'b1;
			end else begin
				move = 1'b1;
			end
		end
		if (do_line_end && rows_dec == 8'd0) begin
			done = 1'b1;
		end
	end

	// state update
	always_comb begin
		active_d       = active_q;
		left_x_d       = left_x_q;
		cursor_x_d     = cursor_x_q;
		cursor_y_d     = cursor_y_q;
		column_d       = column_q;
		phase_d        = phase_q;
		column_limit_d = column_limit_q;
		rows_left_d    = rows_left_q;
		line_count_d   = line_count_q;
		held_color_d   = held_color_q;
		if (req_type_s1 == REQ_BEGIN) begin
			active_d = 1'b0;
			if (!off_screen) begin
				active_d       = 1'b1;
				left_x_d       = start_x_s1;
				cursor_x_d     = start_x_s1;
				cursor_y_d     = start_y_s1;
				column_d       = 8'd0;
				phase_d        = '0;
				column_limit_d = cols;
				rows_left_d    = rows;
				line_count_d   = 8'd0;
				held_color_d   = ink_color_s1;
			end
		end else if (active_q) begin
			if (do_line_end) begin
				line_count_d = lines_inc;
				rows_left_d  = rows_dec;
				if (rows_dec != 8'd0) begin
					cursor_y_d = cursor_y_q + CELL_PIX;
					column_d   = 8'd0;
					phase_d    = '0;
					cursor_x_d = left_x_q;
				end
			end else if (char_code_s1 == CHAR_CR) begin
				column_d   = 8'd0;
				phase_d    = '0;
				cursor_x_d = left_x_q;
			end else if (move_tab) begin
				column_d   = next_tab[7:0];
				phase_d    = '0;
				cursor_x_d = cursor_x_q + TAB_PIX;
			end else if (move) begin
				column_d   = next_col[7:0];
				phase_d    = (phase_q == PH_LAST) ? '0 : phase_q + PW'(1);
				cursor_x_d = cursor_x_q + CELL_PIX;
			end
			if (done) begin
				active_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			left_x_q       <= '0;
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			column_q       <= '0;
			phase_q        <= '0;
			column_limit_q <= '0;
			rows_left_q    <= '0;
			line_count_q   <= '0;
			held_color_q   <= '0;
		end else if (advance) begin
			active_q       <= active_d;
			left_x_q       <= left_x_d;
			cursor_x_q     <= cursor_x_d;
			cursor_y_q     <= cursor_y_d;
			column_q       <= column_d;
			phase_q        <= phase_d;
			column_limit_q <= column_limit_d;
			rows_left_q    <= rows_left_d;
			line_count_q   <= line_count_d;
			held_color_q   <= held_color_d;
		end
	end

	// result assembly
	always_comb begin
		glyph_res             = '0;
		glyph_res.kind        = KIND_GLYPH;
		glyph_res.pixel_x     = cursor_x_q;
		glyph_res.pixel_y     = cursor_y_q;
		glyph_res.symbol      = char_code_s1;
		glyph_res.glyph_color = held_color_q;
		glyph_res.last        = !done;

		finish_res             = '0;
		finish_res.kind        = KIND_FINISH;
		finish_res.lines_ended = do_line_end ? lines_inc : line_count_q;
		finish_res.last        = 1'b1;

		push = '0;
		if (advance) begin
			if (req_type_s1 == REQ_BEGIN) begin
				if (off_screen) begin
					finish_res.lines_ended = 8'd0;
					push.count = 2'd1;
					push.first = finish_res;
				end
			end else if (active_q) begin
				if (glyph && done) begin
					push.count  = 2'd2;
					push.first  = glyph_res;
					push.second = finish_res;
				end else if (glyph) begin
					push.count = 2'd1;
					push.first = glyph_res;
				end else if (done) begin
					push.count = 2'd1;
					push.first = finish_res;
				end
			end
		end
	end

endmodule

// ----- src/tcl_outq.sv -----
// ----------------------------------------------------------------------------
// tcl_outq
// small result queue, takes up to two results per cycle, sends one per beat
// ----------------------------------------------------------------------------
module tcl_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  tcl_pkg::tcl_push_t push,
	output logic               room,
	tcl_result_if.source       result
);
	import tcl_pkg::*;

	tcl_result_t     entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            pop;
	logic [Q_AW-1:0] wr_ptr_nx;
	tcl_result_t     head;

	assign room      = (count_q <= (Q_AW + 1)'(Q_DEPTH - 2));
	assign pop       = result.valid && result.ready;
	assign wr_ptr_nx = wr_ptr_q + Q_AW'(1);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			count_q <= count_q + (Q_AW + 1)'(push.count) - (Q_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_nx] <= push.second;
		end
	end

	assign result.valid       = (count_q != '0);
	assign result.kind        = head.kind;
	assign result.pixel_x     = head.pixel_x;
	assign result.pixel_y     = head.pixel_y;
	assign result.symbol      = head.symbol;
	assign result.glyph_color = head.glyph_color;
	assign result.lines_ended = head.lines_ended;
	assign result.last        = head.last;

endmodule

// ----- src/text_cursor_layout.sv -----
// ----------------------------------------------------------------------------
// text_cursor_layout
// flow: an item is registered in the input stage, decided there once the queue
//   has room, and its results are registered in the queue before the port
// throughput: one item per cycle while the queue has room for two results, set
//   by the cursor state in tcl_layout and the result port, one result per beat
// reset: arst_n clears the cursor state (no string active) and empties the queue
// ----------------------------------------------------------------------------
module text_cursor_layout #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 200,
	parameter int TAB_COLS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	tcl_item_if.sink     item,
	tcl_result_if.source result
);
	import tcl_pkg::*;

	// results of one item on their way to the queue
	tcl_push_t push;
	// queue can take two more results
	logic      room;

	// input register, cursor state and layout decision
	tcl_layout #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H),
		.TAB_COLS (TAB_COLS)
	) u_layout (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.room   (room),
		.push   (push)
	);

	// result queue decouples the stalling result port from the item stream
	tcl_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for text_cursor_layout
// drives begin and character beats through the item channel, keeps a cursor
// predictor in a scoreboard class and checks every result beat in order,
// with random gaps on both channels and one long result stall
// ----------------------------------------------------------------------------
module testbench;
	import tcl_pkg::*;

	// geometry of the block under test, kept equal to its parameters
	localparam int SCREEN_W = 320;
	localparam int SCREEN_H = 200;
	localparam int TAB_COLS = 4;

	// run shape
	localparam int N_RANDOM     = 1650;
	localparam int HOLD_OFF     = 300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 10;

	// one input beat as the sender sees it
	typedef struct packed {
		logic       req_type;
		logic [9:0] start_x;
		logic [9:0] start_y;
		logic [7:0] max_cols;
		logic [7:0] max_rows;
		logic [7:0] ink_color;
		logic [7:0] char_code;
	} layout_req_t;

	// cursor predictor plus the queue of result beats still owed by the block
	class layout_scoreboard;
		int          screen_w;
		int          screen_h;
		int          tab_cols;
		bit          active;
		logic [9:0]  left_x;
		logic [9:0]  cur_x;
		logic [9:0]  cur_y;
		logic [7:0]  column;
		logic [7:0]  col_limit;
		logic [7:0]  rows_left;
		logic [7:0]  line_count;
		logic [7:0]  ink;
		tcl_result_t expected_q[$];
		int          n_items;
		int          n_begins;
		int          n_ignored;
		int          n_glyphs;
		int          n_finishes;
		int          n_checked;
		int          n_errors;

		function new(int w, int h, int t);
			screen_w   = w;
			screen_h   = h;
			tab_cols   = t;
			active     = 1'b0;
			left_x     = '0;
			cur_x      = '0;
			cur_y      = '0;
			column     = '0;
			col_limit  = '0;
			rows_left  = '0;
			line_count = '0;
			ink        = '0;
			n_items    = 0;
			n_begins   = 0;
			n_ignored  = 0;
			n_glyphs   = 0;
			n_finishes = 0;
			n_checked  = 0;
			n_errors   = 0;
		endfunction

		function string show(tcl_result_t r);
			return $sformatf("kind=%0d x=%0d y=%0d sym=%02h color=%02h lines=%0d last=%0d",
				r.kind, r.pixel_x, r.pixel_y, r.symbol, r.glyph_color, r.lines_ended,
				r.last);
		endfunction

		// line end, returns 1 when the last row is used up
		function bit close_line();
			if (line_count != 8'hFF)
				line_count = line_count + 8'd1;
			rows_left = rows_left - 8'd1;
			if (rows_left == 8'd0)
				return 1'b1;
			cur_y  = cur_y + 10'(CELL);
			column = '0;
			cur_x  = left_x;
			return 1'b0;
		endfunction

		// notes one accepted input beat, returns 1 when the block ignores it
		function bit note_item(layout_req_t it);
			tcl_result_t batch[$];
			tcl_result_t r;
			int          cols;
			int          rows;
			int          nxt;
			bit          done;

			n_items++;
			done = 1'b0;
			if (it.req_type == REQ_BEGIN) begin
				n_begins++;
				cols   = screen_w / CELL - int'(it.start_x) / CELL;
				rows   = screen_h / CELL - int'(it.start_y) / CELL;
				active = 1'b0;
				if (cols <= 0 || rows <= 0) begin
					r      = '0;
					r.kind = KIND_FINISH;
					r.last = 1'b1;
					expected_q.push_back(r);
					return 1'b0;
				end
				if (it.max_cols != 8'd0 && int'(it.max_cols) < cols)
					cols = int'(it.max_cols);
				if (it.max_rows != 8'd0 && int'(it.max_rows) < rows)
					rows = int'(it.max_rows);
				left_x     = it.start_x;
				cur_x      = it.start_x;
				cur_y      = it.start_y;
				column     = '0;
				col_limit  = 8'(cols);
				rows_left  = 8'(rows);
				line_count = '0;
				ink        = it.ink_color;
				active     = 1'b1;
				return 1'b0;
			end

			if (!active) begin
				n_ignored++;
				return 1'b1;
			end

			case (it.char_code)
				CHAR_NUL: done = 1'b1;
				CHAR_LF:  done = close_line();
				CHAR_CR: begin
					column = '0;
					cur_x  = left_x;
				end
				CHAR_TAB: begin
					nxt = (int'(column) / tab_cols) * tab_cols + tab_cols;
					if (nxt >= int'(col_limit))
						done = close_line();
					else begin
						column = 8'(nxt);
						cur_x  = cur_x + 10'(tab_cols * CELL);
					end
				end
				default: begin
					if (it.char_code != CHAR_SPACE) begin
						r             = '0;
						r.kind        = KIND_GLYPH;
						r.pixel_x     = cur_x;
						r.pixel_y     = cur_y;
						r.symbol      = it.char_code;
						r.glyph_color = ink;
						batch.push_back(r);
					end
					nxt = int'(column) + 1;
					if (nxt >= int'(col_limit))
						done = close_line();
					else begin
						column = 8'(nxt);
						cur_x  = cur_x + 10'(CELL);
					end
				end
			endcase

			if (done) begin
				r             = '0;
				r.kind        = KIND_FINISH;
				r.lines_ended = line_count;
				batch.push_back(r);
				active = 1'b0;
			end
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i])
				expected_q.push_back(batch[i]);
			return 1'b0;
		endfunction

		function void check_result(tcl_result_t got);
			tcl_result_t exp;

			n_checked++;
			if (got.kind == KIND_FINISH)
				n_finishes++;
			else
				n_glyphs++;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected result beat: %s", show(got));
				return;
			end
			exp = expected_q.pop_front();
			if (got.kind !== exp.kind || got.pixel_x !== exp.pixel_x ||
				got.pixel_y !== exp.pixel_y || got.symbol !== exp.symbol ||
				got.glyph_color !== exp.glyph_color ||
				got.lines_ended !== exp.lines_ended || got.last !== exp.last) begin
				n_errors++;
				if (n_errors <= 10) begin
					$display("result mismatch at beat %0d", n_checked);
					$display("  expected %s", show(exp));
					$display("  actual   %s", show(got));
				end
			end
		endfunction

		function void flag_leftover();
			if (expected_q.size() > 0) begin
				n_errors += expected_q.size();
				$display("%0d expected result beats never arrived, oldest: %s",
					expected_q.size(), show(expected_q[0]));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	tcl_item_if   item_bus();
	tcl_result_if result_bus();

	layout_scoreboard board = new(SCREEN_W, SCREEN_H, TAB_COLS);

	// burst modes switch idling off for a stretch on either side
	bit          send_burst;
	bit          recv_burst;
	bit          pressure_done;
	int          counted;
	int          idle_cycles;
	tcl_result_t got_beat;

	text_cursor_layout #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H),
		.TAB_COLS(TAB_COLS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// begin beat, the character field carries noise
	function automatic layout_req_t begin_req(int sx, int sy, int mc, int mr, int ink_c);
		layout_req_t it;
		it.req_type  = REQ_BEGIN;
		it.start_x   = 10'(sx);
		it.start_y   = 10'(sy);
		it.max_cols  = 8'(mc);
		it.max_rows  = 8'(mr);
		it.ink_color = 8'(ink_c);
		it.char_code = 8'($urandom_range(255, 0));
		return it;
	endfunction

	// character beat, the begin fields carry noise
	function automatic layout_req_t char_req(logic [7:0] code);
		layout_req_t it;
		it.req_type  = REQ_CHAR;
		it.start_x   = 10'($urandom_range(1023, 0));
		it.start_y   = 10'($urandom_range(1023, 0));
		it.max_cols  = 8'($urandom_range(255, 0));
		it.max_rows  = 8'($urandom_range(255, 0));
		it.ink_color = 8'($urandom_range(255, 0));
		it.char_code = code;
		return it;
	endfunction

	// weighted character mix: printable text with control codes sprinkled in
	function automatic logic [7:0] rand_char();
		int r;
		r = $urandom_range(99, 0);
		if (r < 55) return 8'($urandom_range(126, 33));
		if (r < 65) return 8'($urandom_range(255, 0));
		if (r < 75) return CHAR_SPACE;
		if (r < 83) return CHAR_TAB;
		if (r < 89) return CHAR_LF;
		if (r < 94) return CHAR_CR;
		return CHAR_NUL;
	endfunction

	// random begin aimed mostly at the screen, with small limits favored
	function automatic layout_req_t rand_begin();
		int sx;
		int sy;
		int mc;
		int mr;
		int r;
		sx = ($urandom_range(99, 0) < 80) ? $urandom_range(SCREEN_W - 1, 0)
			: $urandom_range(1023, 0);
		sy = ($urandom_range(99, 0) < 80) ? $urandom_range(SCREEN_H - 1, 0)
			: $urandom_range(1023, 0);
		r = $urandom_range(99, 0);
		if (r < 35)      mc = $urandom_range(8, 1);
		else if (r < 55) mc = 0;
		else if (r < 80) mc = $urandom_range(48, 9);
		else             mc = $urandom_range(255, 0);
		r = $urandom_range(99, 0);
		if (r < 50)      mr = $urandom_range(4, 1);
		else if (r < 65) mr = 0;
		else             mr = $urandom_range(255, 0);
		return begin_req(sx, sy, mc, mr, $urandom_range(255, 0));
	endfunction

	// offers one beat after a random gap and waits for the handshake
	task automatic push_beat(layout_req_t it);
		int gap;
		gap = pick_gap(send_burst);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid     <= 1'b1;
		item_bus.req_type  <= it.req_type;
		item_bus.start_x   <= it.start_x;
		item_bus.start_y   <= it.start_y;
		item_bus.max_cols  <= it.max_cols;
		item_bus.max_rows  <= it.max_rows;
		item_bus.ink_color <= it.ink_color;
		item_bus.char_code <= it.char_code;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		// accepted at this edge; its results pass the input stage and the result queue
		void'(board.note_item(it));
		counted++;
	endtask

	// result monitor: every accepted beat goes straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got_beat.kind        = result_bus.kind;
			got_beat.pixel_x     = result_bus.pixel_x;
			got_beat.pixel_y     = result_bus.pixel_y;
			got_beat.symbol      = result_bus.symbol;
			got_beat.glyph_color = result_bus.glyph_color;
			got_beat.lines_ended = result_bus.lines_ended;
			got_beat.last        = result_bus.last;
			board.check_result(got_beat);
		end
	end

	// receiver: random backpressure, plus one long hold-off so the block fills up
	initial begin
		result_bus.ready <= 1'b0;
		pressure_done = 1'b0;
		recv_burst    = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!pressure_done && board.n_checked >= 80) begin
				pressure_done = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			if ($urandom_range(63, 0) == 0)
				recv_burst = !recv_burst;
			begin : stall
				int hold;
				hold = pick_gap(recv_burst);
				if (hold > 0) begin
					result_bus.ready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
			result_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// watchdog: a long run of cycles without any beat on either channel
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, board.expected_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		item_bus.valid     <= 1'b0;
		item_bus.req_type  <= REQ_BEGIN;
		item_bus.start_x   <= '0;
		item_bus.start_y   <= '0;
		item_bus.max_cols  <= '0;
		item_bus.max_rows  <= '0;
		item_bus.ink_color <= '0;
		item_bus.char_code <= '0;
		arst_n             <= 1'b0;
		send_burst  = 1'b0;
		counted     = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		push_beat(char_req(8'h41));                        // character with no string
		push_beat(begin_req(SCREEN_W, 0, 0, 0, 5));        // start column off screen
		push_beat(begin_req(0, SCREEN_H, 0, 0, 5));        // start row off screen
		push_beat(begin_req(1023, 1023, 255, 255, 255));   // both off, all fields high
		push_beat(begin_req(0, 0, 0, 0, 255));             // full screen, no limits
		push_beat(char_req(8'hFF));
		push_beat(char_req(8'h01));
		push_beat(char_req(CHAR_SPACE));
		push_beat(char_req(CHAR_TAB));
		push_beat(char_req(CHAR_CR));
		push_beat(char_req(CHAR_LF));
		push_beat(char_req(8'h7E));
		push_beat(begin_req(SCREEN_W - 8, SCREEN_H - 8, 255, 255, 0)); // drop old string
		push_beat(char_req(8'h41));                        // glyph ends the last row
		push_beat(char_req(8'h42));                        // after the finish, ignored
		push_beat(begin_req(8, 8, 3, 2, 170));
		push_beat(char_req(CHAR_TAB));                     // tab past the column limit
		push_beat(char_req(CHAR_TAB));                     // ends the last row
		push_beat(begin_req(0, 0, 8, 2, 8'h55));
		push_beat(char_req(8'h78));
		push_beat(char_req(CHAR_NUL));                     // terminator
		push_beat(begin_req(SCREEN_W - 1, SCREEN_H - 1, 0, 1, 1));
		push_beat(char_req(CHAR_LF));                      // newline on the only row
		push_beat(begin_req(0, 0, 40, 0, 0));

		// random part: mostly well-formed strings, some noise
		counted = 0;
		while (counted < N_RANDOM) begin
			if ($urandom_range(7, 0) == 0)
				send_burst = !send_burst;
			if ($urandom_range(99, 0) < 85) begin
				push_beat(rand_begin());
				repeat ($urandom_range(48, 1))
					push_beat(char_req(rand_char()));
				if ($urandom_range(1, 0) == 1)
					push_beat(char_req(CHAR_NUL));
			end else begin
				repeat ($urandom_range(4, 1)) begin
					if ($urandom_range(1, 0) == 1)
						push_beat(char_req(8'($urandom_range(255, 0))));
					else
						push_beat(begin_req($urandom_range(1023, 0), $urandom_range(1023, 0),
							$urandom_range(255, 0), $urandom_range(255, 0),
							$urandom_range(255, 0)));
				end
			end
		end
		item_bus.valid <= 1'b0;

		// drain: all owed beats, then a further wait for stray ones
		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.flag_leftover();

		$display("sent %0d input beats: %0d begins, %0d characters without a string",
			board.n_items, board.n_begins, board.n_ignored);
		$display("checked %0d glyph and %0d finish beats, %0d errors",
			board.n_glyphs, board.n_finishes, board.n_errors);
		if (board.n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/tcl_pkg.sv
src/tcl_if.sv
src/tcl_layout.sv
src/tcl_outq.sv
src/text_cursor_layout.sv
tb/testbench.sv
